>>> hdl/hpm_pkg.sv
// Package for the binary16 multiplier: constants and result type.
// Depends on nothing.
`timescale 1ns / 1ps
package hpm_pkg;
    localparam logic [4:0]  EXP_ALL1  = 5'b11111;
    localparam logic [4:0]  EXP_ZERO  = 5'b00000;
    localparam logic [9:0]  FRAC_ALL1 = 10'b1111111111;
    localparam logic [15:0] QUIET_NAN = 16'h7e00;
    localparam logic [15:0] POS_INF   = 16'h7c00;
    localparam logic [15:0] NEG_MAXF  = 16'hfbff;

    typedef struct packed {
        logic [15:0] product;
        logic        invalid;
        logic        inexact;
        logic        overflow;
        logic        underflow;
    } t_result;
endpackage

>>> hdl/half_precision_multiplier.sv
// Top level of the binary16 multiplier: input register, core, output register.
// Depends on hpm_pkg and hpm_core.
//
//   channel | valid   | ready   | payload
//   input   | i_valid | o_ready | i_operand_a, i_operand_b
//   output  | o_valid | i_ready | o_product, o_invalid, o_inexact, o_overflow, o_underflow
//
// One pair per cycle while the output is not stalled; a pair passes the input register, then the result register.
// The multiply and rounding sit between the two registers in hpm_core.
// Reset clears both valid bits; payload registers are not reset.
// A stalled output holds the result register and, when full, the input register.
`timescale 1ns / 1ps
module half_precision_multiplier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_product,
    output logic        o_invalid,
    output logic        o_inexact,
    output logic        o_overflow,
    output logic        o_underflow
);
    import hpm_pkg::*;

    logic        r_in_v, r_out_v;
    logic [15:0] r_a, r_b;
    t_result     r_res, n_res;
    logic        adv;

    // advance the result register when it is empty or being taken
    assign adv     = !r_out_v || i_ready;
    assign o_ready = !r_in_v || adv;

    hpm_core u_core (.i_a(r_a), .i_b(r_b), .o_res(n_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_ready) r_in_v <= i_valid;
            if (adv) r_out_v <= r_in_v;
        end
    end

    // hold payload on stall
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a <= i_operand_a;
            r_b <= i_operand_b;
        end
        if (adv && r_in_v) r_res <= n_res;
    end

    assign o_valid     = r_out_v;
    assign o_product   = r_res.product;
    assign o_invalid   = r_res.invalid;
    assign o_inexact   = r_res.inexact;
    assign o_overflow  = r_res.overflow;
    assign o_underflow = r_res.underflow;
endmodule

>>> hdl/hpm_core.sv
// Combinational binary16 multiply, round toward positive infinity.
// Depends on hpm_pkg.
`timescale 1ns / 1ps
module hpm_core (
    input  logic [15:0]     i_a,
    input  logic [15:0]     i_b,
    output hpm_pkg::t_result o_res
);
    import hpm_pkg::*;

    logic        sign, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [4:0]  ea, eb, ea1, eb1;
    logic [10:0] ma, mb;
    logic [21:0] prod, norm, lost;
    logic [4:0]  lead;
    logic signed [7:0] bexp, sh;
    logic [5:0]  rsh;
    logic [16:0] bits;
    logic        inx;

    always_comb begin
        sign   = i_a[15] ^ i_b[15];
        ea     = i_a[14:10];
        eb     = i_b[14:10];
        nan_a  = (ea == EXP_ALL1) && (i_a[9:0] != '0);
        nan_b  = (eb == EXP_ALL1) && (i_b[9:0] != '0);
        inf_a  = (ea == EXP_ALL1) && (i_a[9:0] == '0);
        inf_b  = (eb == EXP_ALL1) && (i_b[9:0] == '0);
        zero_a = (ea == EXP_ZERO) && (i_a[9:0] == '0);
        zero_b = (eb == EXP_ZERO) && (i_b[9:0] == '0);
        ma     = {ea != EXP_ZERO, i_a[9:0]};
        mb     = {eb != EXP_ZERO, i_b[9:0]};
        ea1    = (ea == EXP_ZERO) ? 5'd1 : ea;
        eb1    = (eb == EXP_ZERO) ? 5'd1 : eb;
        prod   = ma * mb;
        lead   = 5'd0;
        for (int k = 0; k < 22; k++) begin
            if (prod[k]) lead = 5'(k);
        end
        bexp = 8'(lead) + 8'(ea1) + 8'(eb1) - 8'sd35;
        sh   = 8'(lead) - 8'sd10;
        if (bexp < 8'sd1) begin
            sh   = sh + 8'sd1 - bexp;
            bexp = 8'sd0;
        end
        norm = '0;
        lost = '0;
        rsh  = '0;
        if (sh <= 8'sd0) begin
            norm = prod << 5'(-sh);
        end else begin
            rsh  = (sh > 8'sd22) ? 6'd22 : 6'(sh);
            norm = prod >> rsh;
            lost = prod & ~(22'h3fffff << rsh);
        end
        inx  = (lost != '0);
        if (bexp >= 8'sd1)
            bits = {7'(bexp - 8'sd1), 10'd0} + 17'(norm);
        else
            bits = 17'(norm);
        if (inx && !sign) bits = bits + 17'd1;

        o_res = '{product: '0, invalid: 1'b0, inexact: 1'b0,
                  overflow: 1'b0, underflow: 1'b0};
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
            o_res.product = QUIET_NAN;
            o_res.invalid = 1'b1;
        end else if (inf_a || inf_b) begin
            o_res.product = {sign, POS_INF[14:0]};
        end else if (zero_a || zero_b) begin
            o_res.product = {sign, 15'd0};
        end else if (bits >= 17'(POS_INF)) begin
            o_res.product  = sign ? NEG_MAXF : POS_INF;
            o_res.inexact  = 1'b1;
            o_res.overflow = 1'b1;
        end else begin
            o_res.product   = {sign, bits[14:0]};
            o_res.inexact   = inx;
            o_res.underflow = inx && (bits < 17'h400);
        end
    end
endmodule

>>> hdl/hpm_checker.sv
// Port-level checks for the binary16 multiplier, bound to the top level.
// Depends on half_precision_multiplier.
`timescale 1ns / 1ps
module hpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_product,
    input logic        o_invalid,
    input logic        o_inexact,
    input logic        o_overflow,
    input logic        o_underflow
);
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_product == 16'h7e00 && !o_inexact)
        else $error("invalid result not quiet NaN");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_inexact && !o_underflow)
        else $error("overflow without inexact");
    a_unf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_underflow |-> o_inexact && o_product[14:10] == 5'd0)
        else $error("underflow on non-tiny result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_product))
        else $error("stalled result changed");
endmodule

bind half_precision_multiplier hpm_checker u_hpm_checker (.*);
